### sv/fsmr_pkg.sv
// Shared types, command and status codes, and the initial graph for the FSM block.
`default_nettype none

package fsmr_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [2:0] CMD_STEP       = 3'd0;
  localparam logic [2:0] CMD_SET_EDGE   = 3'd1;
  localparam logic [2:0] CMD_LIST       = 3'd2;
  localparam logic [2:0] CMD_DELETE_ONE = 3'd3;
  localparam logic [2:0] CMD_DELETE_ALL = 3'd4;

  // Result status codes carried on the output tuser.
  localparam logic [2:0] ST_OK              = 3'd0;
  localparam logic [2:0] ST_NO_GARBAGE      = 3'd1;
  localparam logic [2:0] ST_REFUSED         = 3'd2;
  localparam logic [2:0] ST_NOT_LOCATED     = 3'd3;
  localparam logic [2:0] ST_NOTHING_DELETED = 3'd4;
  localparam logic [2:0] ST_BAD_TARGET      = 3'd5;

  // At most LAST_SLOT+1 garbage nodes are reported for one request.
  localparam logic [2:0] LAST_SLOT = 3'd7;

  // Edges of states A..H after reset: edge 0 ("last"), edge 1 ("next").
  localparam logic [2:0] INIT_EDGES [8][2] = '{
    '{3'd5, 3'd4}, '{3'd2, 3'd3}, '{3'd2, 3'd7}, '{3'd0, 3'd6},
    '{3'd6, 3'd2}, '{3'd1, 3'd3}, '{3'd4, 3'd1}, '{3'd5, 3'd0}
  };

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_POP,
    S_POP_WAIT,
    S_CHECK0,
    S_CHECK1,
    S_MARKED,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

### sv/fsmr_edge_mem.sv
// Edge table memory: one row of two successor edges per node, registered read.
`default_nettype none

module fsmr_edge_mem #(
  parameter int NODES = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              re,
  input  wire logic [$clog2(NODES)-1:0]          raddr,
  input  wire logic                              we,
  input  wire logic [$clog2(NODES)-1:0]          waddr,
  input  wire logic [2*$clog2(NODES)-1:0]        wdata,
  output logic      [2*$clog2(NODES)-1:0]        rdata
);
  import fsmr_pkg::*;

  localparam int NW = $clog2(NODES);

  logic [2*NW-1:0] mem [NODES];
  logic [NODES-1:0] written;
  logic [2*NW-1:0] rd_data;
  logic [NW-1:0]   rd_addr;
  logic            rd_written;
  logic [2*NW-1:0] init_row [NODES];

  // Reset contents of every row, worked out at elaboration.
  for (genvar i = 0; i < NODES; i++) begin : g_init
    assign init_row[i] = {NW'(INIT_EDGES[i % 8][1] % NODES),
                          NW'(INIT_EDGES[i % 8][0] % NODES)};
  end

  // Storage array with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
      rd_addr <= raddr;
    end
  end

  // Per-row written flags; a row never written reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rd_written <= written[raddr];
      end
    end
  end

  assign rdata = rd_written ? rd_data : init_row[rd_addr];

endmodule

`default_nettype wire

### sv/fsmr_stack_mem.sv
// Work stack memory for the reachability walk, registered read.
`default_nettype none

module fsmr_stack_mem #(
  parameter int NODES = 8
) (
  input  wire logic                       clk,
  input  wire logic                       re,
  input  wire logic [$clog2(NODES)-1:0]   raddr,
  input  wire logic                       we,
  input  wire logic [$clog2(NODES)-1:0]   waddr,
  input  wire logic [$clog2(NODES)-1:0]   wdata,
  output logic      [$clog2(NODES)-1:0]   rdata
);
  localparam int NW = $clog2(NODES);

  logic [NW-1:0] mem [NODES];

  // Storage array with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/programmable_fsm_reachability.sv
// Programmable state machine with reachability marking and garbage deletion.
// Step and set-edge requests give their single result from the registered edge-table row.
// List and delete requests walk the graph: for each reachable node a stack read, an
// edge-table read and a check of each edge, then S_POP finds the stack empty, S_MARKED
// decides, then for a listing or delete-all with garbage a scan of the node indices,
// one per cycle but held on a garbage node while the output register is still full.
// Reset restores the initial graph A..H, all nodes live, and current state C.
`default_nettype none

module programmable_fsm_reachability #(
  parameter int NODES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // edge_select[0], node[3:1], zero pad[7:4]
  input  wire logic [2:0] s_axis_tuser,   // command[2:0]
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // node_id[2:0], zero pad[7:3]
  output logic      [2:0] m_axis_tuser,   // status[2:0]
  output logic            m_axis_tlast    // last_result
);
  import fsmr_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam logic [NW-1:0] CUR_RESET = NW'(2 % NODES);

  state_t state, state_next;

  // Request registers.
  logic [2:0] cmd_q;
  logic       sel_q;
  logic [2:0] node_q;

  // Graph state held in registers.
  logic [NW-1:0]    cur;
  logic [NODES-1:0] live;
  logic [NODES-1:0] reach;
  logic [NODES-1:0] gmask;
  logic [NW:0]      sp;
  logic [NW-1:0]    idx;
  logic [2:0]       cnt;

  // Output register.
  logic       out_valid;
  logic [2:0] out_id;
  logic [2:0] out_status;
  logic       out_last;

  // Memory ports.
  logic            e_re, e_we;
  logic [NW-1:0]   e_raddr, e_waddr;
  logic [2*NW-1:0] e_wdata, e_rdata;
  logic            k_re, k_we;
  logic [NW-1:0]   k_raddr, k_waddr, k_wdata, k_rdata;

  // Control strobes from the state machine.
  logic            out_free;
  logic            emit;
  logic [2:0]      emit_id;
  logic [2:0]      emit_status;
  logic            emit_last;
  logic            take;
  logic            mark_start;
  logic            cur_load;
  logic            sp_dec;
  logic            push;
  logic            del_one;
  logic            scan_start;
  logic            scan_adv;
  logic [NW-1:0]   step_t;
  logic [NW-1:0]   chk_t;
  logic [NW-1:0]   node_idx;
  logic            node_ok;
  logic [NODES-1:0] garbage;
  logic            more_garbage;

  fsmr_edge_mem #(.NODES(NODES)) u_edges (
    .clk   (clk),
    .rst   (rst),
    .re    (e_re),
    .raddr (e_raddr),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .rdata (e_rdata)
  );

  fsmr_stack_mem #(.NODES(NODES)) u_stack (
    .clk   (clk),
    .re    (k_re),
    .raddr (k_raddr),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .rdata (k_rdata)
  );

  // Helper values derived from the registered request and the edge row.
  assign out_free     = !out_valid || m_axis_tready;
  assign node_idx     = NW'(node_q);
  assign node_ok      = (32'(node_q) < NODES) && live[node_idx];
  assign step_t       = sel_q ? e_rdata[2*NW-1:NW] : e_rdata[NW-1:0];
  assign chk_t        = (state == S_CHECK1) ? e_rdata[2*NW-1:NW] : e_rdata[NW-1:0];
  assign garbage      = live & ~reach;
  assign more_garbage = ((gmask >> idx) >> 1) != '0;

  // Next state and control strobes.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    emit          = 1'b0;
    emit_id       = '0;
    emit_status   = ST_OK;
    emit_last     = 1'b1;
    take          = 1'b0;
    mark_start    = 1'b0;
    cur_load      = 1'b0;
    sp_dec        = 1'b0;
    push          = 1'b0;
    del_one       = 1'b0;
    scan_start    = 1'b0;
    scan_adv      = 1'b0;
    e_re          = 1'b0;
    e_raddr       = cur;
    e_we          = 1'b0;
    e_waddr       = cur;
    e_wdata       = sel_q ? {node_idx, e_rdata[NW-1:0]} : {e_rdata[2*NW-1:NW], node_idx};
    k_re          = 1'b0;
    k_raddr       = NW'(sp - 1'b1);
    k_we          = 1'b0;
    k_waddr       = sp[NW-1:0];
    k_wdata       = chk_t;

    unique case (state) inside
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          take = 1'b1;
          unique case (s_axis_tuser) inside
            CMD_STEP, CMD_SET_EDGE: begin
              e_re       = 1'b1;
              state_next = S_EDGE;
            end
            CMD_LIST, CMD_DELETE_ONE, CMD_DELETE_ALL: begin
              // Seed the walk with the current state.
              k_we       = 1'b1;
              k_waddr    = '0;
              k_wdata    = cur;
              mark_start = 1'b1;
              state_next = S_POP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_EDGE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (cmd_q == CMD_STEP) begin
            if (live[step_t]) begin
              emit_id  = 3'(step_t);
              cur_load = 1'b1;
            end else begin
              emit_id     = 3'(cur);
              emit_status = ST_NOT_LOCATED;
            end
          end else begin
            emit_id = node_q;
            if (node_ok) begin
              e_we = 1'b1;
            end else begin
              emit_status = ST_BAD_TARGET;
            end
          end
        end
      end

      S_POP: begin
        if (sp == '0) begin
          state_next = S_MARKED;
        end else begin
          k_re       = 1'b1;
          sp_dec     = 1'b1;
          state_next = S_POP_WAIT;
        end
      end

      S_POP_WAIT: begin
        e_re       = 1'b1;
        e_raddr    = k_rdata;
        state_next = S_CHECK0;
      end

      S_CHECK0, S_CHECK1: begin
        // Push an edge target that is live and not yet marked.
        if (live[chk_t] && !reach[chk_t]) begin
          k_we = 1'b1;
          push = 1'b1;
        end
        state_next = (state == S_CHECK0) ? S_CHECK1 : S_POP;
      end

      S_MARKED: begin
        if (cmd_q == CMD_DELETE_ONE) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_id    = node_q;
            state_next = S_IDLE;
            if (!node_ok) begin
              emit_status = ST_NOT_LOCATED;
            end else if (reach[node_idx]) begin
              emit_status = ST_REFUSED;
            end else begin
              del_one = 1'b1;
            end
          end
        end else if (garbage == '0) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = (cmd_q == CMD_LIST) ? ST_NO_GARBAGE : ST_NOTHING_DELETED;
            state_next  = S_IDLE;
          end
        end else begin
          scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        if (gmask[idx]) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_id   = 3'(idx);
            emit_last = (cnt == LAST_SLOT) || !more_garbage;
            if (emit_last) begin
              state_next = S_IDLE;
            end else begin
              scan_adv = 1'b1;
            end
          end
        end else begin
          scan_adv = 1'b1;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q  <= s_axis_tuser;
      sel_q  <= s_axis_tdata[0];
      node_q <= s_axis_tdata[3:1];
    end
  end

  // Graph state: current node, live and reach masks, stack pointer, scan position.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= CUR_RESET;
      live  <= '1;
      reach <= '0;
      gmask <= '0;
      sp    <= '0;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      if (cur_load) begin
        cur <= step_t;
      end
      if (mark_start) begin
        reach <= NODES'(1) << cur;
        sp    <= (NW+1)'(1);
      end
      if (sp_dec) begin
        sp <= sp - 1'b1;
      end
      if (push) begin
        reach[chk_t] <= 1'b1;
        sp           <= sp + 1'b1;
      end
      if (del_one) begin
        live[node_idx] <= 1'b0;
      end
      if (scan_start) begin
        gmask <= garbage;
        idx   <= '0;
        cnt   <= '0;
        if (cmd_q == CMD_DELETE_ALL) begin
          live <= live & ~garbage;
        end
      end
      if (scan_adv) begin
        idx <= idx + 1'b1;
        if (emit) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Output register: loads a result when the slot is free, clears when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_id     <= emit_id;
      out_status <= emit_status;
      out_last   <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_id};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

### tb/tb_programmable_fsm_reachability.sv
// Self-checking stream testbench for the programmable state machine with garbage deletion.
`timescale 1ns / 100ps

module tb_programmable_fsm_reachability;
  import fsmr_pkg::*;

  localparam int RANDOM_REQS = 450;
  localparam int QUIET_FROM = 150;
  localparam int QUIET_TO = 260;
  localparam int HOLDOFF_AT = 120;
  localparam int HOLDOFF_LEN = 300;
  localparam int TAIL_CYCLES = 100;
  localparam int STALL_LIMIT = 2000;

  // Graph after reset, edge 0 then edge 1 for states A..H.
  localparam logic [2:0] START_EDGES [8][2] = '{
    '{3'd5, 3'd4}, '{3'd2, 3'd3}, '{3'd2, 3'd7}, '{3'd0, 3'd6},
    '{3'd6, 3'd2}, '{3'd1, 3'd3}, '{3'd4, 3'd1}, '{3'd5, 3'd0}
  };

  typedef struct packed {
    logic [2:0] cmd;
    logic       sel;
    logic [2:0] node;
    logic       wait_drain;
  } request_t;

  typedef struct packed {
    logic [2:0] node_id;
    logic [2:0] status;
    logic       last;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // edge_select[0], node[3:1], zero pad[7:4]
  logic [2:0] s_axis_tuser = 3'd0;   // command[2:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // node_id[2:0], zero pad[7:3]
  logic [2:0] m_axis_tuser;          // status[2:0]
  logic m_axis_tlast;

  request_t requests_to_send[$];
  reply_t replies_due[$];

  // Shadow copy of the block's graph.
  logic [2:0] graph_edges [8][2];
  logic [7:0] graph_live;
  logic [2:0] graph_current;

  int reqs_accepted = 0;
  int replies_seen = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  bit req_taken = 1'b0;

  programmable_fsm_reachability u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Nodes reachable from the current state, following edges into live nodes only.
  function automatic logic [7:0] reachable_set();
    logic [7:0] seen;
    seen = 8'd0;
    seen[graph_current] = 1'b1;
    for (int pass = 0; pass < 8; pass++) begin
      for (int n = 0; n < 8; n++) begin
        if (seen[n]) begin
          for (int e = 0; e < 2; e++) begin
            if (graph_live[graph_edges[n][e]]) seen[graph_edges[n][e]] = 1'b1;
          end
        end
      end
    end
    return seen;
  endfunction

  // Apply one request to the shadow graph and queue the replies it causes.
  task automatic run_request(input logic [2:0] cmd, input logic sel, input logic [2:0] node);
    logic [2:0] target;
    logic [7:0] reach;
    reply_t batch[8];
    int k;
    k = 0;
    case (cmd) inside
      CMD_STEP: begin
        target = graph_edges[graph_current][sel];
        if (graph_live[target]) begin
          graph_current = target;
          replies_due.push_back('{target, ST_OK, 1'b1});
        end else begin
          replies_due.push_back('{graph_current, ST_NOT_LOCATED, 1'b1});
        end
      end
      CMD_SET_EDGE: begin
        if (!graph_live[node]) begin
          replies_due.push_back('{node, ST_BAD_TARGET, 1'b1});
        end else begin
          graph_edges[graph_current][sel] = node;
          replies_due.push_back('{node, ST_OK, 1'b1});
        end
      end
      CMD_LIST, CMD_DELETE_ALL: begin
        reach = reachable_set();
        for (int i = 0; i < 8; i++) begin
          if (graph_live[i] && !reach[i]) begin
            if (cmd == CMD_DELETE_ALL) graph_live[i] = 1'b0;
            if (k < 8) begin
              batch[k] = '{i[2:0], ST_OK, 1'b0};
              k++;
            end
          end
        end
        if (k == 0) begin
          replies_due.push_back('{3'd0, (cmd == CMD_LIST) ? ST_NO_GARBAGE : ST_NOTHING_DELETED,
                                  1'b1});
        end else begin
          batch[k - 1].last = 1'b1;
          for (int j = 0; j < k; j++) replies_due.push_back(batch[j]);
        end
      end
      CMD_DELETE_ONE: begin
        reach = reachable_set();
        if (!graph_live[node]) begin
          replies_due.push_back('{node, ST_NOT_LOCATED, 1'b1});
        end else if (reach[node]) begin
          replies_due.push_back('{node, ST_REFUSED, 1'b1});
        end else begin
          graph_live[node] = 1'b0;
          replies_due.push_back('{node, ST_OK, 1'b1});
        end
      end
      default: ;
    endcase
  endtask

  // Sample both handshakes, predict accepted requests and check returned replies.
  always @(posedge clk) begin
    reply_t want;
    bit reply_taken;
    req_taken = 1'b0;
    reply_taken = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req_taken = 1'b1;
        run_request(s_axis_tuser, s_axis_tdata[0], s_axis_tdata[3:1]);
        reqs_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        reply_taken = 1'b1;
        replies_seen++;
        if (replies_due.size() == 0) begin
          $error("unexpected reply: node_id %0d, status %0d, last %0b",
                 m_axis_tdata[2:0], m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tdata[2:0] !== want.node_id) begin
            $error("node_id mismatch: expected %0d, actual %0d", want.node_id, m_axis_tdata[2:0]);
            mismatches++;
          end
          if (m_axis_tdata[7:3] !== 5'd0) begin
            $error("pad mismatch: expected 0, actual %0d", m_axis_tdata[7:3]);
            mismatches++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_result mismatch: expected %0b, actual %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      stall_cycles = (req_taken || reply_taken) ? 0 : stall_cycles + 1;
    end
  end

  // Request driver: presents the next pending request once the current one is taken.
  always @(negedge clk) begin
    request_t nxt;
    bit quiet;
    quiet = (reqs_accepted >= QUIET_FROM) && (reqs_accepted < QUIET_TO);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (requests_to_send.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (requests_to_send[0].wait_drain && replies_due.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 8) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt = requests_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, nxt.node, nxt.sel};
        s_axis_tuser <= nxt.cmd;
      end
    end
  end

  // Reply receiver: random stalls, one long hold-off, and a stretch with no stalls.
  always @(negedge clk) begin
    int holdoff_left;
    bit holdoff_done;
    bit quiet;
    quiet = (replies_seen >= QUIET_FROM) && (replies_seen < QUIET_TO);
    if (rst) begin
      holdoff_left = 0;
      holdoff_done = 1'b0;
      m_axis_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else if (!holdoff_done && replies_seen >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(99) < 8) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no handshake completes.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_programmable_fsm_reachability failed");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    request_t item;
    int counted;
    int roll;

    for (int n = 0; n < 8; n++) begin
      graph_edges[n][0] = START_EDGES[n][0];
      graph_edges[n][1] = START_EDGES[n][1];
    end
    graph_live = 8'hff;
    graph_current = 3'd2;

    // Directed part: empty listing and deletion, refusals, isolation of one state,
    // deletion of dead and live nodes, a step into a dead node, and unknown commands.
    requests_to_send.push_back('{CMD_LIST, 1'b0, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_DELETE_ALL, 1'b1, 3'd7, 1'b0});
    requests_to_send.push_back('{CMD_DELETE_ONE, 1'b0, 3'd2, 1'b0});
    requests_to_send.push_back('{CMD_STEP, 1'b0, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_STEP, 1'b1, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_SET_EDGE, 1'b0, 3'd7, 1'b0});
    requests_to_send.push_back('{CMD_SET_EDGE, 1'b1, 3'd7, 1'b0});
    requests_to_send.push_back('{CMD_LIST, 1'b1, 3'd7, 1'b0});
    requests_to_send.push_back('{CMD_DELETE_ONE, 1'b0, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_DELETE_ONE, 1'b1, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_SET_EDGE, 1'b1, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_SET_EDGE, 1'b1, 3'd1, 1'b0});
    requests_to_send.push_back('{CMD_LIST, 1'b0, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_DELETE_ALL, 1'b0, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_STEP, 1'b1, 3'd7, 1'b0});
    requests_to_send.push_back('{CMD_STEP, 1'b1, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_STEP, 1'b0, 3'd0, 1'b0});
    requests_to_send.push_back('{3'd5, 1'b1, 3'd7, 1'b0});
    requests_to_send.push_back('{3'd6, 1'b0, 3'd3, 1'b0});
    requests_to_send.push_back('{3'd7, 1'b0, 3'd0, 1'b0});
    requests_to_send.push_back('{CMD_DELETE_ONE, 1'b1, 3'd7, 1'b0});

    // Random part; deletions stay rare since a deleted node never comes back.
    counted = 0;
    while (counted < RANDOM_REQS) begin
      roll = $urandom_range(99);
      item.sel = 1'($urandom_range(1));
      item.node = 3'($urandom_range(7));
      item.wait_drain = (counted == 0) || (counted == RANDOM_REQS / 2);
      if (roll < 3) begin
        item.cmd = 3'($urandom_range(7, 5));
      end else begin
        if (roll < 38) item.cmd = CMD_STEP;
        else if (roll < 72) item.cmd = CMD_SET_EDGE;
        else if (roll < 88) item.cmd = CMD_LIST;
        else if (roll < 95) item.cmd = CMD_DELETE_ONE;
        else if (counted > 3 * RANDOM_REQS / 4) item.cmd = CMD_DELETE_ALL;
        else item.cmd = CMD_LIST;
        counted++;
      end
      requests_to_send.push_back(item);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests_to_send.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_programmable_fsm_reachability passed");
    end else begin
      $display("tb_programmable_fsm_reachability failed");
    end
    $finish;
  end

endmodule
